/* design/buzzer_lockout_reliable_outbox_assert.svh */
// assertion macros for the buzzer lockout outbox design
// used by modules that end with concurrent checks; expects clk_i and rst_ni in scope
`ifndef BUZZER_LOCKOUT_RELIABLE_OUTBOX_ASSERT_SVH
`define BUZZER_LOCKOUT_RELIABLE_OUTBOX_ASSERT_SVH
`ifndef ASSERT_OFF
`define BLRO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("blro check failed");
`define BLRO_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("blro sequence check failed");
`else
`define BLRO_ASSERT(lbl, prop)
`define BLRO_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/blro_pkg.sv */
// shared types and constants for the buzzer lockout outbox
// no dependencies
package blro_pkg;

  localparam int unsigned OUTBOX_DEPTH_DEF = 8;
  localparam int unsigned CMDQ_DEPTH       = 2;
  localparam int unsigned CMDQ_IW          = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW          = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] TIMEOUT_RESET = 8'd8;

  // request codes on req_type
  localparam logic [2:0] REQ_BUZZ    = 3'd0;
  localparam logic [2:0] REQ_START   = 3'd1;
  localparam logic [2:0] REQ_PING    = 3'd2;
  localparam logic [2:0] REQ_SUB     = 3'd3;
  localparam logic [2:0] REQ_CONFIRM = 3'd4;
  localparam logic [2:0] REQ_LINK    = 3'd5;
  localparam logic [2:0] REQ_COOL    = 3'd6;
  localparam logic [2:0] REQ_TICK    = 3'd7;

  localparam logic [1:0] PLAYER_NONE = 2'd0;
  localparam logic [1:0] PLAYER_ONE  = 2'd1;
  localparam logic [1:0] PLAYER_TWO  = 2'd2;

  // lockout phase
  localparam logic [1:0] PH_WAITING  = 2'd0;
  localparam logic [1:0] PH_ARMED    = 2'd1;
  localparam logic [1:0] PH_RESOLVED = 2'd2;

  // state message codes
  localparam logic [1:0] ST_WAITING = 2'd0;
  localparam logic [1:0] ST_ARMED   = 2'd1;
  localparam logic [1:0] ST_PRESSED = 2'd2;

  typedef enum logic [3:0] {
    EV_BUZZ,
    EV_NOP,
    EV_START,
    EV_PING,
    EV_SUB,
    EV_CONFIRM,
    EV_LINK,
    EV_COOL,
    EV_TICK
  } ev_e;

  typedef struct packed {
    ev_e        kind;
    logic [1:0] player;
    logic       enable;
    logic       link_up;
    logic       tx_ready;
  } cmd_t;

  typedef struct packed {
    logic        btn_msg;
    logic [1:0]  player;
    logic [31:0] seq;
    logic [1:0]  state;
  } msg_t;

  typedef struct packed {
    logic        send_valid;
    logic        send_is_button;
    logic [1:0]  send_player;
    logic [31:0] send_seq;
    logic [1:0]  send_state;
    logic        vibrate;
    logic        ping_flash;
    logic        cooldown_start;
    logic        cooldown_stop;
    logic [1:0]  phase_now;
    logic [1:0]  winner_now;
    logic        delivered_now;
  } res_t;

endpackage

/* design/blro_front.sv */
// front end: accepts events, classifies them and buffers them in a short command queue
// depends on blro_pkg
module blro_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [2:0]       req_type_i,
  input  logic [1:0]       player_i,
  input  logic             enable_i,
  input  logic             link_up_i,
  input  logic             tx_ready_i,
  output logic             cmd_valid_o,
  output blro_pkg::cmd_t   cmd_o,
  input  logic             cmd_take_i
);
  import blro_pkg::*;

  cmd_t               cls;
  cmd_t               cmdq_q [CMDQ_DEPTH];
  logic [CMDQ_IW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_IW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CW-1:0] count_q, count_d;
  logic               push, pop;

  // decode request code, buzz from an unknown player becomes a no-op
  always_comb begin
    cls.player   = player_i;
    cls.enable   = enable_i;
    cls.link_up  = link_up_i;
    cls.tx_ready = tx_ready_i;
    unique case (req_type_i)
      REQ_BUZZ:    cls.kind = (player_i == PLAYER_ONE || player_i == PLAYER_TWO) ?
                              EV_BUZZ : EV_NOP;
      REQ_START:   cls.kind = EV_START;
      REQ_PING:    cls.kind = EV_PING;
      REQ_SUB:     cls.kind = EV_SUB;
      REQ_CONFIRM: cls.kind = EV_CONFIRM;
      REQ_LINK:    cls.kind = EV_LINK;
      REQ_COOL:    cls.kind = EV_COOL;
      REQ_TICK:    cls.kind = EV_TICK;
      default:     cls.kind = EV_NOP;
    endcase
  end

  assign busy_o      = (count_q == CMDQ_CW'(CMDQ_DEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = cmdq_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_IW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_IW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmdq_q[wr_ptr_q] <= cls;
    end
  end

endmodule

/* design/blro_back.sv */
// back end: lockout state, circular outbox memory, compaction and transmit decision
// depends on blro_pkg and the assertion macro header
`include "buzzer_lockout_reliable_outbox_assert.svh"

module blro_back #(
  parameter int unsigned DEPTH = blro_pkg::OUTBOX_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  blro_pkg::cmd_t cmd_i,
  output logic           cmd_take_o,
  input  logic [7:0]     timeout_i,
  output logic           done_o,
  output blro_pkg::res_t res_o
);
  import blro_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);
  localparam logic [FW:0]   DEPTH_W  = (FW + 1)'(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_PUSH2 = 4'd2;
  localparam logic [3:0] S_CRD   = 4'd3;
  localparam logic [3:0] S_CWR   = 4'd4;
  localparam logic [3:0] S_CPUSH = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SEND  = 4'd7;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [FW-1:0] b);
    logic [FW:0] s;
    s = (FW + 1)'(a) + (FW + 1)'(b);
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[IW-1:0];
  endfunction

  logic [3:0]    state_q, state_d;
  logic [1:0]    phase_q, phase_d;
  logic [1:0]    winner_q, winner_d;
  logic [31:0]   seq_q, seq_d, seq_inc;
  logic          wconf_q, wconf_d;
  logic          sub_q, sub_d;
  logic          conn_q, conn_d;
  logic          flight_q, flight_d;
  logic [7:0]    age_q, age_d;
  logic [IW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] idx_q, idx_d;
  logic [FW-1:0] kept_q, kept_d;
  logic          vib_q, vib_d;
  logic          flash_q, flash_d;
  logic          cds_q, cds_d;
  logic          cdp_q, cdp_d;
  logic          done_q, done_d;
  cmd_t          cmd_q, cmd_d;
  res_t          res_q, res_d;

  msg_t          mem [DEPTH];
  msg_t          rdata_q;
  logic          we;
  logic [IW-1:0] waddr, raddr, tail;
  msg_t          wdata;
  logic          send_ok;

  assign seq_inc    = seq_q + 32'd1;
  assign tail       = wrap_add(head_q, fill_q);
  assign cmd_take_o = (state_q == S_IDLE);
  assign send_ok    = !flight_q && (fill_q != '0) && conn_q && sub_q && cmd_q.tx_ready;
  assign done_o     = done_q;
  assign res_o      = res_q;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    winner_d = winner_q;
    seq_d    = seq_q;
    wconf_d  = wconf_q;
    sub_d    = sub_q;
    conn_d   = conn_q;
    flight_d = flight_q;
    age_d    = age_q;
    head_d   = head_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    kept_d   = kept_q;
    vib_d    = vib_q;
    flash_d  = flash_q;
    cds_d    = cds_q;
    cdp_d    = cdp_q;
    cmd_d    = cmd_q;
    res_d    = res_q;
    done_d   = 1'b0;
    we       = 1'b0;
    waddr    = tail;
    raddr    = head_q;
    wdata    = '0;

    unique case (state_q)
      S_IDLE: begin
        // head entry is read on the same edge that loads the command
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        vib_d   = 1'b0;
        flash_d = 1'b0;
        cds_d   = 1'b0;
        cdp_d   = 1'b0;
        state_d = S_SRD;
        case (cmd_q.kind)
          EV_BUZZ: begin
            if (phase_q == PH_ARMED) begin
              phase_d  = PH_RESOLVED;
              winner_d = cmd_q.player;
              wconf_d  = 1'b0;
              seq_d    = seq_inc;
              cds_d    = 1'b1;
              vib_d    = 1'b1;
              if (fill_q < FILL_MAX) begin
                we            = 1'b1;
                wdata.btn_msg = 1'b1;
                wdata.player  = cmd_q.player;
                wdata.seq     = seq_inc;
                wdata.state   = ST_WAITING;
                fill_d        = fill_q + 1'b1;
              end
              state_d = S_PUSH2;
            end
          end
          EV_START: begin
            cdp_d    = 1'b1;
            vib_d    = 1'b1;
            phase_d  = PH_ARMED;
            winner_d = PLAYER_NONE;
            if (fill_q < FILL_MAX) begin
              we          = 1'b1;
              wdata.state = ST_ARMED;
              fill_d      = fill_q + 1'b1;
            end
          end
          EV_PING: begin
            flash_d = (phase_q == PH_WAITING);
          end
          EV_SUB: begin
            sub_d    = cmd_q.enable;
            flight_d = 1'b0;
            if (cmd_q.enable) begin
              idx_d   = '0;
              kept_d  = '0;
              state_d = (fill_q == '0) ? S_CPUSH : S_CRD;
            end
          end
          EV_CONFIRM: begin
            if (flight_q) begin
              flight_d = 1'b0;
              if (fill_q != '0) begin
                if (rdata_q.btn_msg) wconf_d = 1'b1;
                head_d = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
                fill_d = fill_q - 1'b1;
              end
            end
          end
          EV_LINK: begin
            conn_d = cmd_q.link_up;
            if (!cmd_q.link_up) begin
              sub_d    = 1'b0;
              flight_d = 1'b0;
            end
          end
          EV_COOL: begin
            phase_d = PH_WAITING;
            if (fill_q < FILL_MAX) begin
              we          = 1'b1;
              wdata.state = ST_WAITING;
              fill_d      = fill_q + 1'b1;
            end
          end
          EV_TICK: begin
            if (flight_q) begin
              if (age_q >= timeout_i) flight_d = 1'b0;
              else                    age_d    = age_q + 8'd1;
            end
          end
          default: begin
          end
        endcase
      end
      S_PUSH2: begin
        // pressed-state message after the button message
        if (fill_q < FILL_MAX) begin
          we          = 1'b1;
          wdata.state = ST_PRESSED;
          fill_d      = fill_q + 1'b1;
        end
        state_d = S_SRD;
      end
      S_CRD: begin
        raddr   = wrap_add(head_q, idx_q);
        state_d = S_CWR;
      end
      S_CWR: begin
        // keep button messages in order, drop state messages
        if (rdata_q.btn_msg) begin
          we     = 1'b1;
          waddr  = wrap_add(head_q, kept_q);
          wdata  = rdata_q;
          kept_d = kept_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = (idx_q + 1'b1 == fill_q) ? S_CPUSH : S_CRD;
      end
      S_CPUSH: begin
        waddr = wrap_add(head_q, kept_q);
        if (kept_q < FILL_MAX) begin
          we          = 1'b1;
          wdata.state = phase_q;
          fill_d      = kept_q + 1'b1;
        end else begin
          fill_d = kept_q;
        end
        state_d = S_SRD;
      end
      S_SRD: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        res_d                = '0;
        res_d.vibrate        = vib_q;
        res_d.ping_flash     = flash_q;
        res_d.cooldown_start = cds_q;
        res_d.cooldown_stop  = cdp_q;
        res_d.phase_now      = phase_q;
        res_d.winner_now     = winner_q;
        res_d.delivered_now  = wconf_q;
        if (send_ok) begin
          flight_d             = 1'b1;
          age_d                = 8'd0;
          res_d.send_valid     = 1'b1;
          res_d.send_is_button = rdata_q.btn_msg;
          if (rdata_q.btn_msg) begin
            res_d.send_player = rdata_q.player;
            res_d.send_seq    = rdata_q.seq;
          end else begin
            res_d.send_state = rdata_q.state;
          end
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_WAITING;
      winner_q <= PLAYER_NONE;
      seq_q    <= '0;
      wconf_q  <= 1'b0;
      sub_q    <= 1'b0;
      conn_q   <= 1'b0;
      flight_q <= 1'b0;
      age_q    <= '0;
      head_q   <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
      kept_q   <= '0;
      vib_q    <= 1'b0;
      flash_q  <= 1'b0;
      cds_q    <= 1'b0;
      cdp_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      winner_q <= winner_d;
      seq_q    <= seq_d;
      wconf_q  <= wconf_d;
      sub_q    <= sub_d;
      conn_q   <= conn_d;
      flight_q <= flight_d;
      age_q    <= age_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      kept_q   <= kept_d;
      vib_q    <= vib_d;
      flash_q  <= flash_d;
      cds_q    <= cds_d;
      cdp_q    <= cdp_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  // outbox memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  `BLRO_ASSERT(a_fill_bound, fill_q <= FILL_MAX)
  `BLRO_ASSERT(a_kept_behind, (state_q == S_CWR) |-> (kept_q <= idx_q && idx_q < fill_q))
  `BLRO_ASSERT_NEXT(a_send_sets_flight, state_q == S_SEND && send_ok, flight_q && age_q == 8'd0)
  `BLRO_ASSERT_NEXT(a_done_spaced, done_q, !done_q)

endmodule

/* design/buzzer_lockout_reliable_outbox.sv */
// top level of the buzzer first-press lockout with a reliable one-at-a-time outbox
// depends on blro_pkg, blro_front and blro_back
//
// An event is taken when start_i is high and busy_o is low; every event yields exactly one
// result, shown for one cycle with done_o high, and the receiver cannot stall it, so results
// must be captured on the cycle they appear. Events pass through a two-entry command queue,
// so busy_o rises only when two events are still waiting. The back-end sequencer handles one
// event at a time over an outbox memory with one write and one read port: a plain event
// passes from queue to result through execute, head reread, send decision and result
// register; a winning buzz adds a second message write, and a subscribe-enable adds
// compaction, reading each queued message once and rewriting only the button ones. The
// timeout register is written via the always-ready cfg channel; write it only while idle.
module buzzer_lockout_reliable_outbox #(
  parameter int unsigned OUTBOX_DEPTH = blro_pkg::OUTBOX_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [1:0]  player_i,
  input  logic        enable_i,
  input  logic        link_up_i,
  input  logic        tx_ready_i,
  // timeout register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // result strobe and fields
  output logic        done_o,
  output logic        send_valid_o,
  output logic        send_is_button_o,
  output logic [1:0]  send_player_o,
  output logic [31:0] send_seq_o,
  output logic [1:0]  send_state_o,
  output logic        vibrate_o,
  output logic        ping_flash_o,
  output logic        cooldown_start_o,
  output logic        cooldown_stop_o,
  output logic [1:0]  phase_now_o,
  output logic [1:0]  winner_now_o,
  output logic        delivered_now_o
);
  import blro_pkg::*;

  logic       cfg_we;
  logic [7:0] timeout_ticks_q;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_take;
  res_t       res;

  // the register write is always accepted, since cfg_ready_o is tied high
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks_q <= cfg_data_i;
    end
  end

  // front: accept, classify, queue
  blro_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .player_i    (player_i),
    .enable_i    (enable_i),
    .link_up_i   (link_up_i),
    .tx_ready_i  (tx_ready_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // back: lockout state, outbox, resend timer, transmit decision
  blro_back #(
    .DEPTH (OUTBOX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .timeout_i   (timeout_ticks_q),
    .done_o      (done_o),
    .res_o       (res)
  );

  // unpack the result transaction onto its ports
  assign send_valid_o     = res.send_valid;
  assign send_is_button_o = res.send_is_button;
  assign send_player_o    = res.send_player;
  assign send_seq_o       = res.send_seq;
  assign send_state_o     = res.send_state;
  assign vibrate_o        = res.vibrate;
  assign ping_flash_o     = res.ping_flash;
  assign cooldown_start_o = res.cooldown_start;
  assign cooldown_stop_o  = res.cooldown_stop;
  assign phase_now_o      = res.phase_now;
  assign winner_now_o     = res.winner_now;
  assign delivered_now_o  = res.delivered_now;

endmodule
